/* sv/bopa_pkg.sv */
// ----------------------------------------------------------------------------
// bopa_pkg
// Shared types and codes for the binary output priority array.
// ----------------------------------------------------------------------------
package bopa_pkg;

    localparam int DEFAULT_NUM_PRIORITIES = 16;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_RELINQUISH_DEFAULT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELIABILITY        = 8'd1;

    // command codes
    localparam logic [2:0] OP_WRITE      = 3'd0;
    localparam logic [2:0] OP_RELINQUISH = 3'd1;
    localparam logic [2:0] OP_SERVICE    = 3'd2;
    localparam logic [2:0] OP_CLEAR      = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DENIED = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;

    // priority level that is never commandable
    localparam logic [7:0] RESERVED_PRIORITY = 8'd6;

    typedef struct packed {
        logic       ok;
        logic [1:0] error_kind;
        logic       cur_value;
        logic       prior_value;
        logic [4:0] command_priority;
        logic       change_flag;
        logic       oos_flag;
        logic       fault;
        logic       notify;
    } result_t;

endpackage

/* sv/binary_output_priority_array.sv */
// ----------------------------------------------------------------------------
// binary_output_priority_array
// Commandable two-state output with a priority array, relinquish default,
// out-of-service control and a change-of-value flag.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   op, value, priority_req, service_flag
//  m_        out        m_valid / m_ready   ok .. notify, one beat per command
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one command beat per cycle while s_ready is high; its result is registered and
// appears in the next cycle unless an earlier result is still held at the output.
// the priority encode over the active mask and the mask update sit between
// the state registers and the result register, so nothing iterates.
// a two-entry output stage (result register plus skid) keeps s_ready high
// while one result waits; s_ready drops only when both entries are full.
// reset clears all masks, flags, config registers and valid bits; cfg_ready is always high.
// ----------------------------------------------------------------------------
module binary_output_priority_array #(
    parameter int NUM_PRIORITIES = bopa_pkg::DEFAULT_NUM_PRIORITIES
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_op,
    input  logic [7:0]                       s_value,
    input  logic [7:0]                       s_priority_req,
    input  logic                             s_service_flag,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_ok,
    output logic [1:0]                       m_error_kind,
    output logic                             m_cur_value,
    output logic                             m_prior_value,
    output logic [4:0]                       m_command_priority,
    output logic                             m_change_flag,
    output logic                             m_oos_flag,
    output logic                             m_fault,
    output logic                             m_notify,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bopa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bopa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bopa_pkg::*;

    localparam int IDX_W = $clog2(NUM_PRIORITIES);
    localparam int PRI_W = $clog2(NUM_PRIORITIES + 1);
    localparam logic [7:0] MAX_PRIORITY = 8'(NUM_PRIORITIES);

    // 1-based lowest active level, 0 if none
    function automatic logic [PRI_W-1:0] lowest_active(input logic [NUM_PRIORITIES-1:0] act);
        logic [PRI_W-1:0] pr;
        pr = '0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
            if (act[i]) begin
                pr = PRI_W'(i + 1);
            end
        end
        return pr;
    endfunction

    function automatic logic present_of(input logic [PRI_W-1:0] pr,
                                        input logic [NUM_PRIORITIES-1:0] vals,
                                        input logic dflt);
        logic [PRI_W-1:0] pm1;
        pm1 = pr - PRI_W'(1);
        if (pr == '0) begin
            return dflt;
        end
        return vals[pm1[IDX_W-1:0]];
    endfunction

    logic [NUM_PRIORITIES-1:0] active_reg, active_next;
    logic [NUM_PRIORITIES-1:0] vmask_reg, vmask_next;
    logic                      oos_reg, oos_next;
    logic                      changed_reg, changed_next;
    logic                      relinquish_default_reg;
    logic [7:0]                reliability_reg;

    result_t                   out_reg, skid_reg, res;
    logic                      out_valid_reg, skid_valid_reg;

    logic                      s_fire;
    logic                      out_free;
    logic [PRI_W-1:0]          pr_before, pr_after;
    logic                      before_val, after_val;
    logic                      in_range, denied;
    logic [7:0]                prio_m1;
    logic [NUM_PRIORITIES-1:0] level_bit;

    assign s_ready   = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;

    assign prio_m1   = s_priority_req - 8'd1;
    assign level_bit = {{(NUM_PRIORITIES-1){1'b0}}, 1'b1} << prio_m1[IDX_W-1:0];

    always_comb begin
        pr_before    = lowest_active(active_reg);
        before_val   = present_of(pr_before, vmask_reg, relinquish_default_reg);
        active_next  = active_reg;
        vmask_next   = vmask_reg;
        oos_next     = oos_reg;
        changed_next = changed_reg;
        res          = '0;
        in_range     = (s_priority_req >= 8'd1) && (s_priority_req <= MAX_PRIORITY)
                       && !((s_op == OP_WRITE) && (s_value > 8'd1));
        denied       = (s_priority_req == RESERVED_PRIORITY);

        unique case (s_op)
            OP_WRITE, OP_RELINQUISH: begin
                if (!in_range) begin
                    res.error_kind = ERR_RANGE;
                end else if (denied) begin
                    res.error_kind = ERR_DENIED;
                end else begin
                    if (s_op == OP_WRITE) begin
                        active_next = active_reg | level_bit;
                        vmask_next  = s_value[0] ? (vmask_reg | level_bit)
                                                 : (vmask_reg & ~level_bit);
                    end else begin
                        active_next = active_reg & ~level_bit;
                        vmask_next  = vmask_reg & ~level_bit;
                    end
                    res.ok     = 1'b1;
                    res.notify = !oos_reg;
                end
            end
            OP_SERVICE: begin
                if (oos_reg != s_service_flag) begin
                    oos_next     = s_service_flag;
                    changed_next = 1'b1;
                end
                res.ok = 1'b1;
            end
            OP_CLEAR: begin
                changed_next = 1'b0;
                res.ok       = 1'b1;
            end
            OP_QUERY: begin
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase

        pr_after  = lowest_active(active_next);
        after_val = present_of(pr_after, vmask_next, relinquish_default_reg);
        // masks only move on an accepted write or relinquish
        if (after_val != before_val) begin
            changed_next = 1'b1;
        end

        res.cur_value        = after_val;
        res.prior_value      = before_val;
        res.command_priority = 5'(pr_after);
        res.change_flag      = changed_next;
        res.oos_flag         = oos_next;
        res.fault            = (reliability_reg != 8'd0);
    end

    // state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg             <= '0;
            vmask_reg              <= '0;
            oos_reg                <= 1'b0;
            changed_reg            <= 1'b0;
            relinquish_default_reg <= 1'b0;
            reliability_reg        <= 8'd0;
        end else begin
            if (s_fire) begin
                active_reg  <= active_next;
                vmask_reg   <= vmask_next;
                oos_reg     <= oos_next;
                changed_reg <= changed_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_RELINQUISH_DEFAULT) begin
                    relinquish_default_reg <= cfg_data[0];
                end else if (cfg_index == REG_RELIABILITY) begin
                    reliability_reg <= cfg_data;
                end
            end
        end
    end

    // output register and skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_fire;
                end
            end else if (s_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (s_fire) begin
            skid_reg <= res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_ok               = out_reg.ok;
    assign m_error_kind       = out_reg.error_kind;
    assign m_cur_value        = out_reg.cur_value;
    assign m_prior_value      = out_reg.prior_value;
    assign m_command_priority = out_reg.command_priority;
    assign m_change_flag      = out_reg.change_flag;
    assign m_oos_flag         = out_reg.oos_flag;
    assign m_fault            = out_reg.fault;
    assign m_notify           = out_reg.notify;

    // skid entry is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a held result");

    a_accept_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> m_valid)
        else $error("accepted beat did not reach the output");

    a_ok_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ok) |-> (m_error_kind == ERR_NONE))
        else $error("accepted command reports an error");

    a_notify_in_service: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_notify) |-> (m_ok && !m_oos_flag))
        else $error("notify on refused command or while out of service");

endmodule

/* tb/bopa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bopa_checker
// Watches the command, result and register channels of the priority array.
// Keeps its own copy of the priority masks, flags and registers, works out
// the result of every accepted command beat and compares each result beat
// against the oldest outstanding one.
// ----------------------------------------------------------------------------
module bopa_checker (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [2:0]                        s_op,
    input  logic [7:0]                        s_value,
    input  logic [7:0]                        s_priority_req,
    input  logic                              s_service_flag,

    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_ok,
    input  logic [1:0]                        m_error_kind,
    input  logic                              m_cur_value,
    input  logic                              m_prior_value,
    input  logic [4:0]                        m_command_priority,
    input  logic                              m_change_flag,
    input  logic                              m_oos_flag,
    input  logic                              m_fault,
    input  logic                              m_notify,

    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bopa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bopa_pkg::CFG_DATA_W-1:0]   cfg_data,

    output int                                mismatches,
    output int                                outstanding
);
    import bopa_pkg::*;

    localparam int LEVELS = DEFAULT_NUM_PRIORITIES;
    localparam int LVL_W  = $clog2(LEVELS);

    logic [LEVELS-1:0] active_levels;
    logic [LEVELS-1:0] level_values;
    logic              oos_state;
    logic              change_state;
    logic              default_value;
    logic [7:0]        reliability_code;
    int                fail_count;
    int                result_count;
    result_t           expected_results[$];

    // 1-based number of the lowest active level, 0 when none
    function automatic logic [4:0] lowest_level(input logic [LEVELS-1:0] act);
        logic [4:0] lvl;
        lvl = 5'd0;
        for (int p = LEVELS - 1; p >= 0; p--) begin
            if (act[p]) begin
                lvl = 5'(p + 1);
            end
        end
        return lvl;
    endfunction

    function automatic logic output_level();
        logic [4:0]       lvl;
        logic [LVL_W-1:0] idx;
        lvl = lowest_level(active_levels);
        idx = LVL_W'(lvl - 5'd1);
        if (lvl == 5'd0) begin
            return default_value;
        end
        return level_values[idx];
    endfunction

    task automatic predict_command(input logic [2:0] op, input logic [7:0] val,
                                   input logic [7:0] prio, input logic svc);
        result_t           r;
        logic [LEVELS-1:0] sel;
        logic              was;
        r   = '0;
        sel = '0;
        was = output_level();
        if (op == OP_WRITE || op == OP_RELINQUISH) begin
            // range check wins over the reserved level
            if (prio == 8'd0 || prio > 8'(LEVELS) || (op == OP_WRITE && val > 8'd1)) begin
                r.error_kind = ERR_RANGE;
            end else if (prio == RESERVED_PRIORITY) begin
                r.error_kind = ERR_DENIED;
            end else begin
                sel = {{(LEVELS-1){1'b0}}, 1'b1} << (prio - 8'd1);
                if (op == OP_WRITE) begin
                    active_levels = active_levels | sel;
                    level_values  = val[0] ? (level_values | sel) : (level_values & ~sel);
                end else begin
                    active_levels = active_levels & ~sel;
                    level_values  = level_values & ~sel;
                end
                if (output_level() != was) begin
                    change_state = 1'b1;
                end
                r.ok     = 1'b1;
                r.notify = !oos_state;
            end
        end else if (op == OP_SERVICE) begin
            if (oos_state != svc) begin
                oos_state    = svc;
                change_state = 1'b1;
            end
            r.ok = 1'b1;
        end else if (op == OP_CLEAR) begin
            change_state = 1'b0;
            r.ok         = 1'b1;
        end else if (op == OP_QUERY) begin
            r.ok = 1'b1;
        end
        r.cur_value        = output_level();
        r.prior_value      = was;
        r.command_priority = lowest_level(active_levels);
        r.change_flag      = change_state;
        r.oos_flag         = oos_state;
        r.fault            = (reliability_code != 8'd0);
        expected_results.push_back(r);
    endtask

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            active_levels    = '0;
            level_values     = '0;
            oos_state        = 1'b0;
            change_state     = 1'b0;
            default_value    = 1'b0;
            reliability_code = 8'd0;
            fail_count       = 0;
            result_count     = 0;
            expected_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            // a result beat never belongs to a command taken at the same edge
            if (m_valid && m_ready) begin
                got = {m_ok, m_error_kind, m_cur_value, m_prior_value,
                       m_command_priority, m_change_flag, m_oos_flag,
                       m_fault, m_notify};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result beat %0d arrived with nothing outstanding", result_count);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result beat %0d mismatch", result_count);
                            $display("  exp: ok=%0d err=%0d pv=%0d prior=%0d prio=%0d",
                                     want.ok, want.error_kind, want.cur_value,
                                     want.prior_value, want.command_priority);
                            $display("       chg=%0d oos=%0d flt=%0d ntf=%0d",
                                     want.change_flag, want.oos_flag,
                                     want.fault, want.notify);
                            $display("  got: ok=%0d err=%0d pv=%0d prior=%0d prio=%0d",
                                     got.ok, got.error_kind, got.cur_value,
                                     got.prior_value, got.command_priority);
                            $display("       chg=%0d oos=%0d flt=%0d ntf=%0d",
                                     got.change_flag, got.oos_flag,
                                     got.fault, got.notify);
                        end
                    end
                end
                result_count++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RELINQUISH_DEFAULT: default_value = cfg_data[0];
                    REG_RELIABILITY:        reliability_code = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_command(s_op, s_value, s_priority_req, s_service_flag);
            end
            mismatches  <= fail_count;
            outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands and register writes into the binary output priority array
// with random gaps and result back-pressure; the checker predicts and
// compares every result beat. Directed corner commands come first, then
// several phases of random commands under different register settings.
// ----------------------------------------------------------------------------
module testbench;
    import bopa_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 320;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [2:0]             s_op = '0;
    logic [7:0]             s_value = '0;
    logic [7:0]             s_priority_req = '0;
    logic                   s_service_flag = 1'b0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_ok;
    logic [1:0]             m_error_kind;
    logic                   m_cur_value;
    logic                   m_prior_value;
    logic [4:0]             m_command_priority;
    logic                   m_change_flag;
    logic                   m_oos_flag;
    logic                   m_fault;
    logic                   m_notify;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     mismatches;
    int                     outstanding;
    int                     stall_cycles = 0;
    logic                   steady = 1'b0;

    binary_output_priority_array i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_value            (s_value),
        .s_priority_req     (s_priority_req),
        .s_service_flag     (s_service_flag),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ok               (m_ok),
        .m_error_kind       (m_error_kind),
        .m_cur_value        (m_cur_value),
        .m_prior_value      (m_prior_value),
        .m_command_priority (m_command_priority),
        .m_change_flag      (m_change_flag),
        .m_oos_flag         (m_oos_flag),
        .m_fault            (m_fault),
        .m_notify           (m_notify),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    bopa_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_value            (s_value),
        .s_priority_req     (s_priority_req),
        .s_service_flag     (s_service_flag),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ok               (m_ok),
        .m_error_kind       (m_error_kind),
        .m_cur_value        (m_cur_value),
        .m_prior_value      (m_prior_value),
        .m_command_priority (m_command_priority),
        .m_change_flag      (m_change_flag),
        .m_oos_flag         (m_oos_flag),
        .m_fault            (m_fault),
        .m_notify           (m_notify),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // result back-pressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 22);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("FAILURE");
        $finish;
    end

    // leaves valid high; the next beat or a gap takes it over
    task automatic send_cmd(input logic [2:0] op, input logic [7:0] val,
                            input logic [7:0] prio, input logic svc);
        while (!steady && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_value        <= val;
        s_priority_req <= prio;
        s_service_flag <= svc;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_cmd(input int write_pct, input int relinquish_pct);
        int         pick;
        logic [2:0] op;
        logic [7:0] val;
        logic [7:0] prio;
        pick = $urandom_range(99);
        if (pick < write_pct) begin
            op = OP_WRITE;
        end else if (pick < write_pct + relinquish_pct) begin
            op = OP_RELINQUISH;
        end else if (pick < write_pct + relinquish_pct + 8) begin
            op = OP_SERVICE;
        end else if (pick < write_pct + relinquish_pct + 16) begin
            op = OP_CLEAR;
        end else if (pick < 97) begin
            op = OP_QUERY;
        end else begin
            op = 3'($urandom_range(7, 5));
        end
        // mostly legal values, some out of range
        if ($urandom_range(99) < 88) begin
            val = 8'($urandom_range(1));
        end else begin
            val = 8'($urandom_range(255));
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
            prio = 8'($urandom_range(16, 1));
        end else if (pick < 89) begin
            prio = RESERVED_PRIORITY;
        end else if (pick < 93) begin
            prio = 8'd0;
        end else begin
            prio = 8'($urandom_range(255, 17));
        end
        send_cmd(op, val, prio, 1'($urandom_range(1)));
    endtask

    initial begin
        logic       dflt;
        logic [7:0] rel;
        int         write_pct;
        int         relinquish_pct;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners under reset register values
        send_cmd(OP_QUERY,      8'd0,   8'd0,   1'b0);
        send_cmd(OP_WRITE,      8'd1,   8'd16,  1'b0);
        send_cmd(OP_WRITE,      8'd0,   8'd1,   1'b0);
        send_cmd(OP_WRITE,      8'd1,   RESERVED_PRIORITY, 1'b0);
        send_cmd(OP_WRITE,      8'd2,   8'd3,   1'b0);
        send_cmd(OP_WRITE,      8'd1,   8'd0,   1'b0);
        send_cmd(OP_WRITE,      8'd1,   8'd17,  1'b0);
        send_cmd(OP_WRITE,      8'd255, 8'd255, 1'b1);
        send_cmd(OP_WRITE,      8'd5,   RESERVED_PRIORITY, 1'b0);
        send_cmd(OP_RELINQUISH, 8'd0,   RESERVED_PRIORITY, 1'b0);
        send_cmd(OP_RELINQUISH, 8'd255, 8'd0,   1'b0);
        send_cmd(OP_CLEAR,      8'd0,   8'd0,   1'b0);
        send_cmd(OP_SERVICE,    8'd0,   8'd0,   1'b1);
        send_cmd(OP_SERVICE,    8'd0,   8'd0,   1'b1);
        send_cmd(OP_WRITE,      8'd1,   8'd2,   1'b0);
        send_cmd(OP_RELINQUISH, 8'd0,   8'd1,   1'b0);
        send_cmd(OP_SERVICE,    8'd0,   8'd0,   1'b0);
        send_cmd(3'd5,          8'd1,   8'd1,   1'b1);
        send_cmd(3'd6,          8'd0,   8'd2,   1'b0);
        send_cmd(3'd7,          8'd1,   8'd16,  1'b1);
        send_cmd(OP_RELINQUISH, 8'd0,   8'd2,   1'b0);
        send_cmd(OP_RELINQUISH, 8'd0,   8'd16,  1'b0);
        send_cmd(OP_RELINQUISH, 8'd0,   8'd16,  1'b0);
        drain_results();
        // default and fault change without touching the change flag
        write_reg(REG_RELINQUISH_DEFAULT, 8'd1);
        write_reg(REG_RELIABILITY, 8'd255);
        send_cmd(OP_QUERY, 8'd0, 8'd0, 1'b0);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin dflt = 1'b0; rel = 8'd0;   write_pct = 45; relinquish_pct = 25; end
                1: begin dflt = 1'b1; rel = 8'd255; write_pct = 25; relinquish_pct = 45; end
                2: begin dflt = 1'b1; rel = 8'd0;   write_pct = 40; relinquish_pct = 35; end
                3: begin dflt = 1'b0; rel = 8'd128; write_pct = 30; relinquish_pct = 40; end
                4: begin dflt = 1'b0; rel = 8'd1;   write_pct = 50; relinquish_pct = 20; end
                default: begin
                    dflt = 1'b1; rel = 8'd127; write_pct = 35; relinquish_pct = 35;
                end
            endcase
            write_reg(REG_RELINQUISH_DEFAULT, {7'd0, dflt});
            write_reg(REG_RELIABILITY, rel);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // back-to-back stretch on both channels
                if (ph == 2) begin
                    steady <= (n < 250);
                end
                random_cmd(write_pct, relinquish_pct);
            end
            steady <= 1'b0;
            drain_results();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
